// ----- hdl/crc8f_pkg.sv -----
`default_nettype none
package crc8f_pkg;

  // default number of parameter bytes a frame may carry
  localparam int unsigned MAX_PARAMS_DEF = 16;

  // reset value of the start byte register ('P')
  localparam logic [7:0] START_BYTE_RST = 8'h50;

  // CRC-8 generator polynomial and seed
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [2:0] REG_START_BYTE = 3'd0;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_LEN_ERR = 2'd2
  } status_e;

  // front parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD,
    PH_LEN,
    PH_PARAM,
    PH_CRC
  } phase_e;

  // back sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_OUT
  } back_state_e;

  // one frame outcome handed from front to back
  typedef struct packed {
    status_e    status;
    logic [7:0] command;
    logic [4:0] count;
    logic       bank;
  } job_t;

  // parameter buffer write from the front
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [4:0] idx;
    logic [7:0] data;
  } pwr_t;

  // bank release from the back
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  // bitwise CRC-8 update, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/crc8f_front.sv -----
`default_nettype none
module crc8f_front import crc8f_pkg::*; #(
  parameter int unsigned MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] start_byte_i,
  input  wire logic       rx_valid_i,
  output logic            rx_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            push_o,
  output job_t            job_o,
  input  wire logic       full_i,
  output pwr_t            pwr_o,
  input  wire rel_t       rel_i
);

  localparam logic [7:0] MaxLen = 8'(MAX_PARAMS);

  phase_e     phase_q, phase_d;
  logic [7:0] cmd_q, cmd_d;
  logic [4:0] len_q, len_d;
  logic [4:0] cnt_q, cnt_d;
  logic [7:0] crc_q, crc_d;
  logic       wbank_q, wbank_d;
  logic [1:0] busy_q, busy_d;

  logic       acc_w;
  logic [7:0] crc_next_w;
  logic [4:0] cnt_inc_w;
  logic       too_long_w;

  assign crc_next_w = crc8_update(crc_q, rx_byte_i);
  assign cnt_inc_w  = cnt_q + 5'd1;
  assign too_long_w = rx_byte_i > MaxLen;

  // hold off while a push could find the queue full or the bank is still draining
  always_comb begin
    rx_stall_o = 1'b0;
    case (phase_q)
      PH_LEN, PH_CRC: rx_stall_o = full_i;
      PH_PARAM:       rx_stall_o = busy_q[wbank_q];
      default:        rx_stall_o = 1'b0;
    endcase
  end

  assign acc_w = rx_valid_i && !rx_stall_o;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (acc_w) begin
      case (phase_q)
        PH_IDLE:  if (rx_byte_i == start_byte_i) phase_d = PH_CMD;
        PH_CMD:   phase_d = PH_LEN;
        PH_LEN: begin
          if (too_long_w) begin
            phase_d = PH_IDLE;
          end else if (rx_byte_i == 8'd0) begin
            phase_d = PH_CRC;
          end else begin
            phase_d = PH_PARAM;
          end
        end
        PH_PARAM: if (cnt_inc_w >= len_q) phase_d = PH_CRC;
        PH_CRC:   phase_d = PH_IDLE;
        default:  phase_d = PH_IDLE;
      endcase
    end
  end

  // datapath, buffer writes and job pushes
  always_comb begin
    cmd_d          = cmd_q;
    len_d          = len_q;
    cnt_d          = cnt_q;
    crc_d          = crc_q;
    wbank_d        = wbank_q;
    push_o         = 1'b0;
    job_o.status   = ST_OK;
    job_o.command  = cmd_q;
    job_o.count    = len_q;
    job_o.bank     = wbank_q;
    pwr_o.en       = 1'b0;
    pwr_o.bank     = wbank_q;
    pwr_o.idx      = cnt_q;
    pwr_o.data     = rx_byte_i;
    busy_d         = busy_q;
    if (rel_i.en) busy_d[rel_i.bank] = 1'b0;
    if (acc_w) begin
      case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == start_byte_i) begin
            crc_d = crc8_update(CRC_INIT, rx_byte_i);
            cmd_d = 8'd0;
            len_d = 5'd0;
            cnt_d = 5'd0;
          end
        end
        PH_CMD: begin
          cmd_d = rx_byte_i;
          crc_d = crc_next_w;
        end
        PH_LEN: begin
          crc_d = crc_next_w;
          cnt_d = 5'd0;
          if (too_long_w) begin
            len_d        = 5'd0;
            push_o       = 1'b1;
            job_o.status = ST_LEN_ERR;
            job_o.count  = 5'd0;
          end else begin
            len_d = rx_byte_i[4:0];
          end
        end
        PH_PARAM: begin
          crc_d    = crc_next_w;
          pwr_o.en = 1'b1;
          cnt_d    = cnt_inc_w;
        end
        PH_CRC: begin
          push_o = 1'b1;
          if (rx_byte_i != crc_q) begin
            job_o.status = ST_CRC_ERR;
          end else if (len_q != 5'd0) begin
            // good frame with parameters: hand this bank to the back
            busy_d[wbank_q] = 1'b1;
            wbank_d         = !wbank_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= 8'd0;
      len_q   <= 5'd0;
      cnt_q   <= 5'd0;
      crc_q   <= CRC_INIT;
      wbank_q <= 1'b0;
      busy_q  <= 2'b00;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      wbank_q <= wbank_d;
      busy_q  <= busy_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/crc8f_queue.sv -----
`default_nettype none
module crc8f_queue import crc8f_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output job_t      job_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  job_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == FullCnt;
  assign empty_o = cnt_q == '0;
  assign job_o   = slot_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) slot_q[wptr_q] <= job_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/crc8f_back.sv -----
`default_nettype none
module crc8f_back import crc8f_pkg::*; #(
  parameter int unsigned MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pwr_t       pwr_i,
  input  wire logic       empty_i,
  input  wire job_t       job_i,
  output logic            pop_o,
  output rel_t            rel_o,
  output logic            res_valid_o,
  input  wire logic       res_stall_i,
  output logic [1:0]      status_o,
  output logic [7:0]      command_o,
  output logic [4:0]      param_count_o,
  output logic [3:0]      param_index_o,
  output logic [7:0]      param_byte_o,
  output logic            last_o
);

  localparam int unsigned PW    = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int unsigned Depth = 2 ** (PW + 1);

  // two banks of parameter bytes, one per frame in flight
  logic [7:0]  mem_q [Depth];
  logic [7:0]  rd_q;

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [4:0]  k_q, k_d;
  logic        has_par_w;
  logic        fin_w;
  logic        take_w;

  assign has_par_w = (job_q.status == ST_OK) && (job_q.count != 5'd0);
  assign fin_w     = !has_par_w || ((k_q + 5'd1) == job_q.count);
  assign take_w    = (state_q == BK_OUT) && !res_stall_i;

  always_ff @(posedge clk_i) begin
    if (pwr_i.en) mem_q[{pwr_i.bank, pwr_i.idx[PW-1:0]}] <= pwr_i.data;
    if (state_q == BK_READ) rd_q <= mem_q[{job_q.bank, k_q[PW-1:0]}];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = ((job_i.status == ST_OK) && (job_i.count != 5'd0)) ? BK_READ : BK_OUT;
        end
      end
      BK_READ: state_d = BK_OUT;
      BK_OUT: begin
        if (!res_stall_i) state_d = fin_w ? BK_IDLE : BK_READ;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs and index
  always_comb begin
    pop_o         = (state_q == BK_IDLE) && !empty_i;
    rel_o.en      = take_w && fin_w && has_par_w;
    rel_o.bank    = job_q.bank;
    res_valid_o   = state_q == BK_OUT;
    status_o      = job_q.status;
    command_o     = job_q.command;
    param_count_o = job_q.count;
    param_index_o = k_q[3:0];
    param_byte_o  = has_par_w ? rd_q : 8'd0;
    last_o        = fin_w;
    k_d           = k_q;
    if (pop_o) begin
      k_d = 5'd0;
    end else if (take_w && !fin_w) begin
      k_d = k_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      k_q     <= 5'd0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // job registers are payload
  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
  end

endmodule
`default_nettype wire

// ----- hdl/crc8_command_frame_receiver.sv -----
// Accepts one rx byte per cycle; it stalls only when the job queue is full at a
// length or CRC byte, or when the parameter bank it would fill is still draining.
// The first result follows the accepted CRC or bad length byte through the job queue
// and back job register, a good frame with parameters also a buffer read (later if the
// queue has earlier jobs); each parameter: a read and an output state (one read port).
// Reset clears the parser, queue, bank flags and start byte (0x50); buffer is not cleared.
`default_nettype none
module crc8_command_frame_receiver import crc8f_pkg::*; #(
  parameter int unsigned MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        rx_valid_i,
  output logic             rx_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  input  wire logic        res_stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       command_o,
  output logic [4:0]       param_count_o,
  output logic [3:0]       param_index_o,
  output logic [7:0]       param_byte_o,
  output logic             last_o
);

  logic [7:0] start_q;
  logic [2:0] reg_idx_w;
  logic       push_w, full_w, pop_w, empty_w;
  job_t       fjob_w, bjob_w;
  pwr_t       pwr_w;
  rel_t       rel_w;

  // register file
  assign reg_idx_w = paddr >> 2;
  assign pready    = 1'b1;
  assign prdata    = (reg_idx_w == REG_START_BYTE) ? {24'd0, start_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_BYTE_RST;
    end else if (psel && penable && pwrite && pready && (reg_idx_w == REG_START_BYTE)) begin
      start_q <= pwdata[7:0];
    end
  end

  crc8f_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_byte_i (start_q),
    .rx_valid_i   (rx_valid_i),
    .rx_stall_o   (rx_stall_o),
    .rx_byte_i    (rx_byte_i),
    .push_o       (push_w),
    .job_o        (fjob_w),
    .full_i       (full_w),
    .pwr_o        (pwr_w),
    .rel_i        (rel_w)
  );

  crc8f_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .job_i   (fjob_w),
    .full_o  (full_w),
    .pop_i   (pop_w),
    .empty_o (empty_w),
    .job_o   (bjob_w)
  );

  crc8f_back #(.MAX_PARAMS(MAX_PARAMS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pwr_i         (pwr_w),
    .empty_i       (empty_w),
    .job_i         (bjob_w),
    .pop_o         (pop_w),
    .rel_o         (rel_w),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .status_o      (status_o),
    .command_o     (command_o),
    .param_count_o (param_count_o),
    .param_index_o (param_index_o),
    .param_byte_o  (param_byte_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// ----- bench/crc8_frame_checker.sv -----
`timescale 1ns / 100ps
// Watches the rx, result and register channels of the frame receiver, predicts the
// results of every accepted byte and compares them in order.
module crc8_frame_checker import crc8f_pkg::*; #(
  parameter int unsigned MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  input  wire logic        pready,
  input  wire logic        rx_valid_i,
  input  wire logic        rx_stall_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        res_valid_i,
  input  wire logic        res_stall_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [7:0]  command_i,
  input  wire logic [4:0]  param_count_i,
  input  wire logic [3:0]  param_index_i,
  input  wire logic [7:0]  param_byte_i,
  input  wire logic        last_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_seen_o,
  output logic             parser_idle_o
);

  localparam logic [2:0] START_ADDR = 3'(REG_START_BYTE << 2);

  typedef struct packed {
    status_e    status;
    logic [7:0] command;
    logic [4:0] count;
    logic [3:0] idx;
    logic [7:0] pbyte;
    logic       last;
  } frame_result_t;

  // predicted parser state and register copy
  phase_e        parse_phase;
  logic [7:0]    start_sel;
  logic [7:0]    frame_cmd;
  logic [4:0]    frame_len;
  logic [4:0]    param_cnt;
  logic [7:0]    frame_crc;
  logic [7:0]    param_buf [MAX_PARAMS];
  frame_result_t expected_q [$];

  // serial form of the CRC-8 update, one data bit per step, MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  task automatic push_result(input status_e st, input logic [7:0] cmd, input logic [4:0] cnt,
                             input logic [3:0] ix, input logic [7:0] pb, input logic lst);
    frame_result_t r;
    r.status  = st;
    r.command = cmd;
    r.count   = cnt;
    r.idx     = ix;
    r.pbyte   = pb;
    r.last    = lst;
    expected_q.push_back(r);
  endtask

  // advance the frame parser by one received byte
  task automatic predict_frame_byte(input logic [7:0] b);
    case (parse_phase)
      PH_IDLE: begin
        if (b == start_sel) begin
          frame_crc   = crc8_next(CRC_INIT, b);
          frame_cmd   = '0;
          frame_len   = '0;
          param_cnt   = '0;
          parse_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        frame_cmd   = b;
        frame_crc   = crc8_next(frame_crc, b);
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        frame_crc = crc8_next(frame_crc, b);
        param_cnt = '0;
        if (b > MAX_PARAMS) begin
          push_result(ST_LEN_ERR, frame_cmd, '0, '0, '0, 1'b1);
          frame_len   = '0;
          parse_phase = PH_IDLE;
        end else begin
          frame_len   = b[4:0];
          parse_phase = (b == 0) ? PH_CRC : PH_PARAM;
        end
      end
      PH_PARAM: begin
        frame_crc = crc8_next(frame_crc, b);
        if (param_cnt < MAX_PARAMS) param_buf[param_cnt] = b;
        param_cnt = param_cnt + 1'b1;
        if (param_cnt >= frame_len) parse_phase = PH_CRC;
      end
      PH_CRC: begin
        if (b != frame_crc) begin
          push_result(ST_CRC_ERR, frame_cmd, frame_len, '0, '0, 1'b1);
        end else if (frame_len == 0) begin
          push_result(ST_OK, frame_cmd, '0, '0, '0, 1'b1);
        end else begin
          for (int k = 0; k < frame_len && k < MAX_PARAMS; k++) begin
            push_result(ST_OK, frame_cmd, frame_len, 4'(k), param_buf[k], (k + 1 == frame_len));
          end
        end
        parse_phase = PH_IDLE;
      end
      default: parse_phase = PH_IDLE;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic compare_result();
    frame_result_t want;
    results_seen_o++;
    if (expected_q.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, got cmd 0x%0h code %0d",
               $time, command_i, status_i);
      fail_count_o++;
    end else begin
      want = expected_q.pop_front();
      check_field("result code", int'(want.status), int'(status_i));
      check_field("command", want.command, command_i);
      check_field("param count", want.count, param_count_i);
      check_field("param index", want.idx, param_index_i);
      check_field("param byte", want.pbyte, param_byte_i);
      check_field("last flag", want.last, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_phase    = PH_IDLE;
      start_sel      = START_BYTE_RST;
      frame_cmd      = '0;
      frame_len      = '0;
      param_cnt      = '0;
      frame_crc      = CRC_INIT;
      expected_q.delete();
      fail_count_o   = 0;
      results_seen_o = 0;
      pending_o      = 0;
      parser_idle_o  = 1'b1;
    end else begin
      // results first, so nothing predicted at this edge can be matched here
      if (res_valid_i && !res_stall_i) compare_result();
      // register accesses
      if (psel && penable && pready && paddr == START_ADDR) begin
        if (pwrite) start_sel = pwdata[7:0];
        else check_field("start byte readback", start_sel, prdata[7:0]);
      end
      if (rx_valid_i && !rx_stall_i) predict_frame_byte(rx_byte_i);
      pending_o     = expected_q.size();
      parser_idle_o = (parse_phase == PH_IDLE);
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import crc8f_pkg::*;

  localparam logic [2:0] START_ADDR  = 3'(REG_START_BYTE << 2);
  localparam int         HOLD_CYCLES = 300;
  localparam int         DRAIN_PAD   = 16;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_CUT} frame_kind_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_valid_i  = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  command_o;
  logic [4:0]  param_count_o;
  logic [3:0]  param_index_o;
  logic [7:0]  param_byte_o;
  logic        last_o;

  int   fail_count;
  int   pending;
  int   results_seen;
  logic parser_idle;

  // stimulus bookkeeping
  bit         idling_on   = 1'b1;
  int         holds_asked = 0;
  int         holds_done  = 0;
  logic [7:0] frame_start = START_BYTE_RST;
  logic [7:0] par_q [$];
  int         frame_bytes = 0;
  int         noise_bytes = 0;
  int         n_good = 0, n_crc_bad = 0, n_len_bad = 0, n_cut = 0;
  logic [7:0] last_start;

  crc8_command_frame_receiver DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .rx_valid_i(rx_valid_i), .rx_stall_o(rx_stall_o), .rx_byte_i(rx_byte_i),
    .res_valid_o(res_valid_o), .res_stall_i(res_stall_i),
    .status_o(status_o), .command_o(command_o), .param_count_o(param_count_o),
    .param_index_o(param_index_o), .param_byte_o(param_byte_o), .last_o(last_o)
  );

  crc8_frame_checker #(.MAX_PARAMS(MAX_PARAMS_DEF)) CHK (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .rx_valid_i(rx_valid_i), .rx_stall_i(rx_stall_o), .rx_byte_i(rx_byte_i),
    .res_valid_i(res_valid_o), .res_stall_i(res_stall_i),
    .status_i(status_o), .command_i(command_o), .param_count_i(param_count_o),
    .param_index_i(param_index_o), .param_byte_i(param_byte_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen),
    .parser_idle_o(parser_idle)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: random stall bursts, plus a long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_done < holds_asked) begin
        res_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        res_stall_i <= 1'b0;
        holds_done++;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        res_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        res_stall_i <= 1'b0;
      end
    end
  end

  // CRC-8 of the frame as it is built, poly 0x07, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    repeat (8) v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    return v;
  endfunction

  // offer one byte, holding it until accepted; returns at the next falling edge
  task automatic send_byte(input logic [7:0] b);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [7:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= START_ADDR;
    pwdata  <= {24'h0, data};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) frame_start = data;
  endtask

  // random parameter bytes, now and then the start byte itself
  task automatic fill_params(input int n);
    par_q.delete();
    repeat (n) par_q.push_back(($urandom_range(0, 7) == 0) ? frame_start : 8'($urandom));
  endtask

  // start, command, length, parameters from par_q, CRC
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input frame_kind_e kind);
    logic [7:0] crc;
    int         n_par;
    crc = crc8_step(CRC_INIT, frame_start);
    send_byte(frame_start);
    crc = crc8_step(crc, cmd);
    send_byte(cmd);
    crc = crc8_step(crc, len);
    send_byte(len);
    frame_bytes += 3;
    if (len > MAX_PARAMS_DEF) begin
      n_len_bad++;
      return;
    end
    n_par = (kind == FR_CUT) ? $urandom_range(0, len) : len;
    for (int i = 0; i < n_par; i++) begin
      crc = crc8_step(crc, par_q[i]);
      send_byte(par_q[i]);
      frame_bytes++;
    end
    if (kind == FR_CUT) begin
      n_cut++;
      return;
    end
    frame_bytes++;
    if (kind == FR_BAD_CRC) begin
      n_crc_bad++;
      send_byte(crc ^ (8'h01 << $urandom_range(0, 7)));
    end else begin
      n_good++;
      send_byte(crc);
    end
  endtask

  // one random good or broken frame, or a few bytes of noise
  task automatic random_frame();
    int          pick;
    int          len;
    frame_kind_e kind;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 4);
    kind = (pick < 60) ? FR_GOOD : (pick < 72) ? FR_BAD_CRC : FR_CUT;
    if (pick >= 88) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte(8'($urandom));
        noise_bytes++;
      end
    end else if (pick >= 72 && pick < 80) begin
      send_frame(8'($urandom), ($urandom_range(0, 3) == 0) ? 8'd17 : 8'($urandom_range(17, 255)),
                 FR_GOOD);
    end else begin
      fill_params(len);
      send_frame(8'($urandom), 8'(len), kind);
    end
  endtask

  // random frames until about n frame bytes went in, led by one of full length
  task automatic random_run(input int n);
    int goal;
    goal = frame_bytes + n;
    fill_params(MAX_PARAMS_DEF);
    send_frame(8'($urandom), 8'(MAX_PARAMS_DEF), FR_GOOD);
    while (frame_bytes < goal) random_frame();
  endtask

  // close any open frame, drain all results and let the block go quiet
  task automatic settle();
    while (!parser_idle) begin
      send_byte(~frame_start);
      noise_bytes++;
    end
    rx_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_PAD) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);
    apb_access(1'b0, 8'h00);

    // directed: idle noise, zero length, oversize lengths, bad CRC with the
    // start byte as data, small good frame with extreme parameter values
    send_byte(8'h00);
    send_byte(8'hFF);
    noise_bytes += 2;
    par_q.delete();
    send_frame(8'hFF, 8'd0, FR_GOOD);
    send_frame(8'h00, 8'd255, FR_GOOD);
    send_frame(8'hA5, 8'd17, FR_GOOD);
    par_q.push_back(frame_start);
    send_frame(8'h3C, 8'd1, FR_BAD_CRC);
    par_q.delete();
    par_q.push_back(8'h00);
    par_q.push_back(8'hFF);
    send_frame(8'h5A, 8'd2, FR_GOOD);
    settle();

    // start byte 0x00; long result hold while frames keep coming
    apb_access(1'b1, 8'h00);
    apb_access(1'b0, 8'h00);
    holds_asked++;
    repeat (3) begin
      fill_params(8);
      send_frame(8'($urandom), 8'd8, FR_GOOD);
    end
    random_run(24);
    settle();

    // start byte 0xFF; sender pauses until everything has drained
    apb_access(1'b1, 8'hFF);
    random_run(24);
    rx_valid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    random_run(24);
    settle();

    // random start byte, no idling on either side
    idling_on = 1'b0;
    last_start = 8'($urandom);
    apb_access(1'b1, last_start);
    apb_access(1'b0, 8'h00);
    random_run(24);
    settle();

    $display("covered %0d frame bytes and %0d noise bytes: %0d good, %0d bad-CRC, %0d oversize, %0d cut frames",
             frame_bytes, noise_bytes, n_good, n_crc_bad, n_len_bad, n_cut);
    $display("%0d results compared over start bytes 50, 00, ff, %h, with a long hold and a drain pause",
             results_seen, last_start);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- crc8_command_frame_receiver.f -----
hdl/crc8f_pkg.sv
hdl/crc8f_front.sv
hdl/crc8f_queue.sv
hdl/crc8f_back.sv
hdl/crc8_command_frame_receiver.sv
bench/crc8_frame_checker.sv
bench/tb.sv
